/* hw/rtl/lvs_pkg.sv */
// ----------------------------------------------------------------------------
// lvs_pkg: shared types, constants and control program
// Fixed-point widths, saturation helper and the microcode table of the
// Langevin velocity-Verlet step sequencer.
// ----------------------------------------------------------------------------
`default_nettype none

package lvs_pkg;

    localparam int STATE_WIDTH = 32;
    // saturation range follows STATE_WIDTH, capped by the 32-bit outputs
    localparam int SAT_BITS    = (STATE_WIDTH > 32) ? 32 : ((STATE_WIDTH < 2) ? 2 : STATE_WIDTH);
    localparam int OUT_W       = 32;
    localparam int COEF_W      = 31;
    localparam int GAUSS_W     = 16;
    localparam int MUL_W       = 32;
    localparam int PROD_W      = 2 * MUL_W;
    localparam int ACC_W       = 40;
    localparam int COEF_FRAC   = 30;
    localparam int GAUSS_FRAC  = 12;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 32;
    localparam int PROG_LEN    = 10;
    localparam int PC_W        = $clog2(PROG_LEN);

    localparam logic [COEF_W-1:0] DAMPING_RESET = COEF_W'(1) << COEF_FRAC;

    localparam logic [CFG_IDX_W-1:0] CFG_DAMPING  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_SPRING   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_NOISE    = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEL = CFG_IDX_W'(4);

    localparam logic signed [ACC_W-1:0] SAT_HI =
        ACC_W'((64'sd1 <<< (SAT_BITS - 1)) - 64'sd1);
    localparam logic signed [ACC_W-1:0] SAT_LO = -SAT_HI - ACC_W'(1);

    // coefficient and initial-state registers as seen by the datapath
    typedef struct packed {
        logic [COEF_W-1:0]       damping;
        logic [COEF_W-1:0]       spring;
        logic [COEF_W-1:0]       noise;
        logic signed [OUT_W-1:0] init_pos;
        logic signed [OUT_W-1:0] init_vel;
    } t_coef;

    typedef struct packed {
        logic signed [SAT_BITS-1:0] val;
        logic                       hit;
    } t_sat;

    typedef struct packed {
        logic signed [OUT_W-1:0] pos;
        logic signed [OUT_W-1:0] vel;
        logic                    ovf;
    } t_result;

    // microcode fields
    typedef enum logic [2:0] {A_V, A_Q, A_VS, A_G1, A_G2} t_asel;
    typedef enum logic [1:0] {B_D, B_K, B_S} t_bsel;
    typedef enum logic [1:0] {BASE_ZERO, BASE_ACC, BASE_VS} t_base;
    typedef enum logic [1:0] {ADD_R30, ADD_R12, ADD_Q} t_addend;
    typedef enum logic [1:0] {WR_NONE, WR_VS, WR_Q, WR_V} t_wsel;
    typedef enum logic {JMP_NEXT, JMP_END} t_jump;

    typedef struct packed {
        logic    mul_en;
        t_asel   a;
        t_bsel   b;
        t_base   base;
        t_addend addend;
        logic    add_neg;
        t_wsel   wr;
        t_jump   jump;
    } t_uop;

    localparam t_uop UOP_NOP = '{
        mul_en: 1'b0, a: A_V, b: B_D, base: BASE_ZERO, addend: ADD_R30,
        add_neg: 1'b0, wr: WR_NONE, jump: JMP_NEXT
    };

    function automatic t_sat sat_chk(input logic signed [ACC_W-1:0] x);
        t_sat r;
        if (x > SAT_HI) begin
            r.val = SAT_HI[SAT_BITS-1:0];
            r.hit = 1'b1;
        end else if (x < SAT_LO) begin
            r.val = SAT_LO[SAT_BITS-1:0];
            r.hit = 1'b1;
        end else begin
            r.val = x[SAT_BITS-1:0];
            r.hit = 1'b0;
        end
        return r;
    endfunction

    // Program: vs = d*v - k*q + s*g1; q = q + vs; w = vs - k*q; v = d*w + s*g2.
    // A product issued in one step is rounded and accumulated in the next.
    function automatic t_uop uop_rom(input logic [PC_W-1:0] pc);
        t_uop u;
        u = UOP_NOP;
        unique case (pc)
            PC_W'(0): begin
                u.mul_en = 1'b1; u.a = A_V; u.b = B_D;
            end
            PC_W'(1): begin
                u.mul_en = 1'b1; u.a = A_Q; u.b = B_K;
                u.base = BASE_ZERO; u.addend = ADD_R30;
            end
            PC_W'(2): begin
                u.mul_en = 1'b1; u.a = A_G1; u.b = B_S;
                u.base = BASE_ACC; u.addend = ADD_R30; u.add_neg = 1'b1;
            end
            PC_W'(3): begin
                u.base = BASE_ACC; u.addend = ADD_R12; u.wr = WR_VS;
            end
            PC_W'(4): begin
                u.base = BASE_VS; u.addend = ADD_Q; u.wr = WR_Q;
            end
            PC_W'(5): begin
                u.mul_en = 1'b1; u.a = A_Q; u.b = B_K;
            end
            PC_W'(6): begin
                // w overwrites vs, which is not needed afterwards
                u.base = BASE_VS; u.addend = ADD_R30; u.add_neg = 1'b1; u.wr = WR_VS;
            end
            PC_W'(7): begin
                u.mul_en = 1'b1; u.a = A_VS; u.b = B_D;
            end
            PC_W'(8): begin
                u.mul_en = 1'b1; u.a = A_G2; u.b = B_S;
                u.base = BASE_ZERO; u.addend = ADD_R30;
            end
            PC_W'(9): begin
                u.base = BASE_ACC; u.addend = ADD_R12; u.wr = WR_V; u.jump = JMP_END;
            end
            default: u = UOP_NOP;
        endcase
        return u;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/lvs_sequencer.sv */
// ----------------------------------------------------------------------------
// lvs_sequencer: step counter and control-word fetch
// Walks the microcode table once per item; the last step waits until the
// output register can take the result.
// ----------------------------------------------------------------------------
`default_nettype none

module lvs_sequencer
    import lvs_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_start,     // item accepted this cycle
    input  wire  i_out_busy,  // output register full and not draining
    output logic o_idle,
    output t_uop o_uop,
    output logic o_fire,      // execute the current control word
    output logic o_done       // last step executed, result valid
);

    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_RUN  = 2'b10
    } t_state;

    t_state            r_state, n_state;
    logic [PC_W-1:0]   r_pc, n_pc;
    logic              w_stall;

    assign o_uop  = uop_rom(r_pc);
    assign o_idle = (r_state == ST_IDLE);

    always_comb begin
        n_state = r_state;
        n_pc    = r_pc;
        w_stall = 1'b0;
        o_fire  = 1'b0;
        o_done  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    n_state = ST_RUN;
                    n_pc    = '0;
                end
            end
            ST_RUN: begin
                // hold on the last step while the previous result still waits
                w_stall = (o_uop.jump == JMP_END) && i_out_busy;
                o_fire  = !w_stall;
                if (!w_stall) begin
                    if (o_uop.jump == JMP_END) begin
                        n_state = ST_IDLE;
                        n_pc    = '0;
                        o_done  = 1'b1;
                    end else begin
                        n_pc = r_pc + PC_W'(1);
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
                n_pc    = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_pc    <= '0;
        end else begin
            r_state <= n_state;
            r_pc    <= n_pc;
        end
    end

`ifndef NO_ASSERTIONS
    a_idle_pc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_IDLE) |-> (r_pc == '0))
        else $error("step counter not at zero while idle");

    a_done_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (r_state == ST_IDLE))
        else $error("sequencer did not return to idle after last step");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RUN && !o_fire) |=> ($stable(r_pc) && r_state == ST_RUN))
        else $error("step advanced during a stall");

    a_start_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && r_state == ST_IDLE) |=> (r_state == ST_RUN && r_pc == '0))
        else $error("accepted item did not start the program");
`endif

endmodule

`default_nettype wire

/* hw/rtl/lvs_datapath.sv */
// ----------------------------------------------------------------------------
// lvs_datapath: shared multiplier, accumulator and state registers
// Up to one registered 32x32 multiply per step, rounding and accumulation
// of the previous product, saturating write-back into position, velocity and vs.
// ----------------------------------------------------------------------------
`default_nettype none

module lvs_datapath
    import lvs_pkg::*;
(
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_load,      // item accepted
    input  wire  signed [GAUSS_W-1:0] i_gauss_first,
    input  wire  signed [GAUSS_W-1:0] i_gauss_second,
    input  wire                       i_start_new,
    input  wire  t_coef               i_coef,
    input  wire  t_uop                i_uop,
    input  wire                       i_fire,
    output t_result                   o_res
);

    localparam logic signed [PROD_W-1:0] HALF30 = PROD_W'(1) << (COEF_FRAC - 1);
    localparam logic signed [PROD_W-1:0] HALF12 = PROD_W'(1) << (GAUSS_FRAC - 1);

    logic signed [SAT_BITS-1:0] r_q, r_v, r_vs;
    logic signed [GAUSS_W-1:0]  r_g1, r_g2;
    logic signed [PROD_W-1:0]   r_prod;
    logic signed [ACC_W-1:0]    r_acc;
    logic                       r_ovf;

    logic signed [MUL_W-1:0]    w_ma, w_mb;
    logic signed [PROD_W-1:0]   w_rnd30, w_rnd12;
    logic signed [ACC_W-1:0]    w_r30, w_r12, w_base, w_add, w_sum;
    t_sat                       w_sat, w_ip, w_iv;

    always_comb begin
        case (i_uop.a)
            A_V:     w_ma = MUL_W'(r_v);
            A_Q:     w_ma = MUL_W'(r_q);
            A_VS:    w_ma = MUL_W'(r_vs);
            A_G1:    w_ma = MUL_W'(r_g1);
            A_G2:    w_ma = MUL_W'(r_g2);
            default: w_ma = '0;
        endcase
        case (i_uop.b)
            B_D:     w_mb = MUL_W'({1'b0, i_coef.damping});
            B_K:     w_mb = MUL_W'({1'b0, i_coef.spring});
            B_S:     w_mb = MUL_W'({1'b0, i_coef.noise});
            default: w_mb = '0;
        endcase
    end

    // round to nearest, halves toward +infinity
    assign w_rnd30 = r_prod + HALF30;
    assign w_rnd12 = r_prod + HALF12;
    assign w_r30   = ACC_W'(w_rnd30 >>> COEF_FRAC);
    assign w_r12   = ACC_W'(w_rnd12 >>> GAUSS_FRAC);

    always_comb begin
        case (i_uop.base)
            BASE_ZERO: w_base = '0;
            BASE_ACC:  w_base = r_acc;
            BASE_VS:   w_base = ACC_W'(r_vs);
            default:   w_base = '0;
        endcase
        case (i_uop.addend)
            ADD_R30: w_add = w_r30;
            ADD_R12: w_add = w_r12;
            ADD_Q:   w_add = ACC_W'(r_q);
            default: w_add = '0;
        endcase
        w_sum = i_uop.add_neg ? (w_base - w_add) : (w_base + w_add);
    end

    assign w_sat = sat_chk(w_sum);
    assign w_ip  = sat_chk(ACC_W'(i_coef.init_pos));
    assign w_iv  = sat_chk(ACC_W'(i_coef.init_vel));

    assign o_res.pos = OUT_W'(r_q);
    assign o_res.vel = OUT_W'(w_sat.val);
    assign o_res.ovf = r_ovf | w_sat.hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
            r_v <= '0;
        end else if (i_load) begin
            if (i_start_new) begin
                r_q <= w_ip.val;
                r_v <= w_iv.val;
            end
        end else if (i_fire) begin
            case (i_uop.wr)
                WR_Q:    r_q <= w_sat.val;
                WR_V:    r_v <= w_sat.val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_g1  <= i_gauss_first;
            r_g2  <= i_gauss_second;
            r_ovf <= i_start_new & (w_ip.hit | w_iv.hit);
        end else if (i_fire) begin
            if (i_uop.mul_en) begin
                r_prod <= w_ma * w_mb;
            end
            r_acc <= w_sum;
            if (i_uop.wr == WR_VS) begin
                r_vs <= w_sat.val;
            end
            if (i_uop.wr != WR_NONE) begin
                r_ovf <= r_ovf | w_sat.hit;
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/langevin_verlet_step.sv */
// ----------------------------------------------------------------------------
// langevin_verlet_step: Langevin velocity-Verlet step of a harmonic oscillator
// Microcoded fixed-point integrator with configuration registers and a
// registered result stage.
// ----------------------------------------------------------------------------
//  channel   dir  handshake           payload
//  s_*       in   s_tvalid/s_tready   tdata: gauss_first, gauss_second; tuser: start_new
//  m_*       out  m_tvalid/m_tready   tdata: position, velocity; tuser: overflow
//  cfg       in   i_cfg_valid/o_cfg_ready  index, data (always ready)
//
//  An accepted item runs ten program steps through the single shared
//  multiplier, whose product is registered before it is rounded and
//  accumulated; the last step loads the output register.
//  A new item is accepted only when idle, in the cycle after the last step,
//  while the result may still wait; the last step holds while the output
//  register is full and not taken. Reset is synchronous, active low.
// ----------------------------------------------------------------------------
`default_nettype none

module langevin_verlet_step
    import lvs_pkg::*;
(
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   s_tvalid,
    output logic                  s_tready,
    input  wire  [31:0]           s_tdata,   // [15:0] gauss_first, [31:16] gauss_second
    input  wire                   s_tuser,   // [0] start_new
    output logic                  m_tvalid,
    input  wire                   m_tready,
    output logic [63:0]           m_tdata,   // [31:0] position, [63:32] velocity
    output logic                  m_tuser,   // [0] overflow
    input  wire                   i_cfg_valid,
    output logic                  o_cfg_ready,
    input  wire  [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire  [CFG_DATA_W-1:0] i_cfg_data
);

    t_coef      r_coef;
    t_uop       w_uop;
    t_result    w_res;
    logic       w_idle, w_fire, w_done, w_load, w_out_busy;
    logic       r_m_tvalid;
    t_result    r_m_res;

    assign o_cfg_ready = 1'b1;
    assign s_tready    = w_idle;
    assign w_load      = s_tvalid & w_idle;
    assign w_out_busy  = r_m_tvalid & ~m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef.damping  <= DAMPING_RESET;
            r_coef.spring   <= '0;
            r_coef.noise    <= '0;
            r_coef.init_pos <= '0;
            r_coef.init_vel <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_DAMPING:  r_coef.damping  <= i_cfg_data[COEF_W-1:0];
                CFG_SPRING:   r_coef.spring   <= i_cfg_data[COEF_W-1:0];
                CFG_NOISE:    r_coef.noise    <= i_cfg_data[COEF_W-1:0];
                CFG_INIT_POS: r_coef.init_pos <= i_cfg_data[OUT_W-1:0];
                CFG_INIT_VEL: r_coef.init_vel <= i_cfg_data[OUT_W-1:0];
                default: ;
            endcase
        end
    end

    lvs_sequencer u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_load),
        .i_out_busy (w_out_busy),
        .o_idle     (w_idle),
        .o_uop      (w_uop),
        .o_fire     (w_fire),
        .o_done     (w_done)
    );

    lvs_datapath u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_load         (w_load),
        .i_gauss_first  (s_tdata[15:0]),
        .i_gauss_second (s_tdata[31:16]),
        .i_start_new    (s_tuser),
        .i_coef         (r_coef),
        .i_uop          (w_uop),
        .i_fire         (w_fire),
        .o_res          (w_res)
    );

    // output register: load on the last step, drop when taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (w_done) begin
            r_m_tvalid <= 1'b1;
        end else if (m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_done) begin
            r_m_res <= w_res;
        end
    end

    assign m_tvalid = r_m_tvalid;
    assign m_tdata  = {r_m_res.vel, r_m_res.pos};
    assign m_tuser  = r_m_res.ovf;

endmodule

`default_nettype wire
